### rtl/core/rgberode_pkg.sv
// Shared constants and types for the RGB 3x3 erosion filter.
package rgberode_pkg;

    localparam int LINE_PIXELS_DEF  = 2048;
    localparam int CHANNEL_BITS_DEF = 8;
    localparam int NUM_CH           = 3;
    localparam int QUEUE_DEPTH      = 4;

    localparam int WIDTH_BITS  = 12;
    localparam int HEIGHT_BITS = 13;
    localparam int ROW_BITS    = 13;
    localparam int MAX_LINES   = 4096;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_IDX_W   = 1;

    localparam logic [WIDTH_BITS-1:0]  WIDTH_RST  = 12'd640;
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RST = 13'd480;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic emit;
        logic left_is_center;
        logic use_right;
        logic eol;
        logic eof;
    } t_win_ctrl;

endpackage

### rtl/core/rgberode_fifo.sv
// Small show-ahead queue with occupancy count.
module rgberode_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr, n_wptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + CNT_W'(1);
            2'b01:   n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rptr];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

endmodule

### rtl/core/rgberode_front.sv
// Front end: raster position, line stores and per-column vertical minimum.
module rgberode_front #(
    parameter int MAX_LINE_PIXELS = rgberode_pkg::LINE_PIXELS_DEF,
    parameter int CHANNEL_BITS    = rgberode_pkg::CHANNEL_BITS_DEF,
    parameter int QUEUE_DEPTH     = rgberode_pkg::QUEUE_DEPTH
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [rgberode_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [rgberode_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                                  push,
    output logic                                  full,
    input  logic                                  i_kind,
    input  logic [CHANNEL_BITS-1:0]               i_red_in,
    input  logic [CHANNEL_BITS-1:0]               i_green_in,
    input  logic [CHANNEL_BITS-1:0]               i_blue_in,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0]      i_mq_count,
    output logic                                  o_mq_push,
    output rgberode_pkg::t_win_ctrl               o_ctrl,
    output logic [rgberode_pkg::NUM_CH*CHANNEL_BITS-1:0] o_colmin
);
    import rgberode_pkg::*;

    localparam int COL_W = $clog2(MAX_LINE_PIXELS);
    localparam int EW    = (COL_W + 1 > WIDTH_BITS) ? COL_W + 1 : WIDTH_BITS;
    localparam int PIX_W = NUM_CH * CHANNEL_BITS;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH_BITS-1:0]  r_width;
    logic [HEIGHT_BITS-1:0] r_height;
    logic [COL_W-1:0]       r_col, n_col;
    logic [ROW_BITS-1:0]    r_row, n_row;

    logic                   r_b_valid;
    logic [COL_W-1:0]       r_b_addr;
    logic [PIX_W-1:0]       r_b_px;
    logic                   r_b_pixel;
    logic                   r_b_top;
    t_win_ctrl              r_b_ctrl;
    logic [2*PIX_W-1:0]     r_rd;
    logic [2*PIX_W-1:0]     r_line_mem [MAX_LINE_PIXELS];

    logic [ROW_BITS-1:0]    h_eff, h_p1, eff_r;
    logic [EW-1:0]          w_ext, w_m1;
    logic [COL_W-1:0]       eff_c;
    logic                   acc, work, restart_px, ignore, last_col, cfg_hit;
    t_win_ctrl              ctrl;
    logic [CNT_W:0]         pending;
    logic [PIX_W-1:0]       px, up, mid, bot;
    logic [2*PIX_W-1:0]     wdata;
    logic                   fwd;

    function automatic logic [CHANNEL_BITS-1:0] ch_min(
        input logic [CHANNEL_BITS-1:0] a,
        input logic [CHANNEL_BITS-1:0] b
    );
        return (a < b) ? a : b;
    endfunction

    assign pending = {1'b0, i_mq_count} + (CNT_W + 1)'(r_b_valid);
    assign full    = (pending >= (CNT_W + 1)'(QUEUE_DEPTH));
    assign acc     = push & ~full;
    assign px      = {i_blue_in, i_green_in, i_red_in};

    always_comb begin
        if (r_height == '0) begin
            h_eff = ROW_BITS'(1);
        end else if (ROW_BITS'(r_height) > ROW_BITS'(MAX_LINES)) begin
            h_eff = ROW_BITS'(MAX_LINES);
        end else begin
            h_eff = ROW_BITS'(r_height);
        end
        h_p1  = h_eff + ROW_BITS'(1);
        w_ext = EW'(r_width);
        if (r_width == '0) begin
            w_m1 = '0;
        end else if (w_ext > EW'(MAX_LINE_PIXELS)) begin
            w_m1 = EW'(MAX_LINE_PIXELS - 1);
        end else begin
            w_m1 = w_ext - EW'(1);
        end

        restart_px = ~i_kind & (r_row >= h_eff);
        ignore     = i_kind & (r_row < h_eff);
        work       = acc & ~ignore;
        eff_r      = restart_px ? '0 : r_row;
        eff_c      = restart_px ? '0 : r_col;
        last_col   = (EW'(eff_c) == w_m1);

        ctrl.emit           = (eff_r >= ROW_BITS'(2)) |
                              ((eff_r == ROW_BITS'(1)) & (eff_c != '0));
        ctrl.use_right      = (eff_c != '0);
        ctrl.left_is_center = (eff_c != '0) ? (eff_c == COL_W'(1)) : (w_m1 == '0);
        ctrl.eol            = (eff_c == '0);
        ctrl.eof            = (eff_c == '0) & (eff_r == h_p1);

        if (ctrl.emit & ctrl.eof) begin
            n_col = '0;
            n_row = '0;
        end else if (last_col) begin
            n_col = '0;
            n_row = eff_r + ROW_BITS'(1);
        end else begin
            n_col = eff_c + COL_W'(1);
            n_row = eff_r;
        end
    end

    always_comb begin
        case (t_cfg_idx'(i_cfg_idx))
            CFG_WIDTH:  cfg_hit = i_cfg_we;
            CFG_HEIGHT: cfg_hit = i_cfg_we;
            default:    cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= WIDTH_RST;
            r_height  <= HEIGHT_RST;
            r_col     <= '0;
            r_row     <= '0;
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= work;
            if (cfg_hit) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_WIDTH:  r_width  <= i_cfg_data[WIDTH_BITS-1:0];
                    CFG_HEIGHT: r_height <= i_cfg_data[HEIGHT_BITS-1:0];
                    default:    r_width  <= r_width;
                endcase
                r_col <= '0;
                r_row <= '0;
            end else if (work) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (work) begin
            r_b_addr  <= eff_c;
            r_b_px    <= px;
            r_b_pixel <= ~i_kind;
            r_b_top   <= (eff_r == ROW_BITS'(1));
            r_b_ctrl  <= ctrl;
        end
    end

    // entry holds {two lines back, one line back}
    assign wdata = {r_rd[PIX_W-1:0], r_b_px};
    assign fwd   = r_b_valid & r_b_pixel & (r_b_addr == eff_c);

    always_ff @(posedge i_clk) begin
        if (work) begin
            r_rd <= fwd ? wdata : r_line_mem[eff_c];
        end
        if (r_b_valid & r_b_pixel) begin
            r_line_mem[r_b_addr] <= wdata;
        end
    end

    assign up  = r_rd[2*PIX_W-1:PIX_W];
    assign mid = r_rd[PIX_W-1:0];
    assign bot = r_b_pixel ? r_b_px : mid;

    for (genvar k = 0; k < NUM_CH; k++) begin : g_ch
        logic [CHANNEL_BITS-1:0] mb;
        assign mb = ch_min(mid[k*CHANNEL_BITS +: CHANNEL_BITS],
                           bot[k*CHANNEL_BITS +: CHANNEL_BITS]);
        assign o_colmin[k*CHANNEL_BITS +: CHANNEL_BITS] =
            r_b_top ? mb : ch_min(up[k*CHANNEL_BITS +: CHANNEL_BITS], mb);
    end

    assign o_mq_push = r_b_valid;
    assign o_ctrl    = r_b_ctrl;

endmodule

### rtl/core/rgberode_back.sv
// Back end: three-column window, horizontal minimum and result queue.
module rgberode_back #(
    parameter int CHANNEL_BITS = rgberode_pkg::CHANNEL_BITS_DEF,
    parameter int QUEUE_DEPTH  = rgberode_pkg::QUEUE_DEPTH
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_mq_empty,
    input  rgberode_pkg::t_win_ctrl                      i_ctrl,
    input  logic [rgberode_pkg::NUM_CH*CHANNEL_BITS-1:0] i_colmin,
    output logic                                         o_mq_pop,
    input  logic                                         pop,
    output logic                                         empty,
    output logic [CHANNEL_BITS-1:0]                      o_red_out,
    output logic [CHANNEL_BITS-1:0]                      o_green_out,
    output logic [CHANNEL_BITS-1:0]                      o_blue_out,
    output logic                                         o_end_of_line,
    output logic                                         o_end_of_frame
);
    import rgberode_pkg::*;

    localparam int PIX_W = NUM_CH * CHANNEL_BITS;
    localparam int OQ_W  = PIX_W + 2;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [PIX_W-1:0] r_win0, r_win1, r_win2;
    t_win_ctrl        r_d_ctrl;
    logic             r_d_valid;

    logic [CNT_W-1:0] oq_count;
    logic [CNT_W:0]   oq_pending;
    logic             space, oq_empty;
    logic [PIX_W-1:0] left, right, res;
    logic [OQ_W-1:0]  oq_wdata, oq_rdata;

    function automatic logic [CHANNEL_BITS-1:0] ch_min(
        input logic [CHANNEL_BITS-1:0] a,
        input logic [CHANNEL_BITS-1:0] b
    );
        return (a < b) ? a : b;
    endfunction

    assign oq_pending = {1'b0, oq_count} + (CNT_W + 1)'(r_d_valid);
    assign space      = (oq_pending < (CNT_W + 1)'(QUEUE_DEPTH));
    assign o_mq_pop   = ~i_mq_empty & space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else begin
            r_d_valid <= o_mq_pop & i_ctrl.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_mq_pop) begin
            r_win0   <= r_win1;
            r_win1   <= r_win2;
            r_win2   <= i_colmin;
            r_d_ctrl <= i_ctrl;
        end
    end

    assign left  = r_d_ctrl.left_is_center ? r_win1 : r_win0;
    assign right = r_d_ctrl.use_right ? r_win2 : r_win1;

    for (genvar k = 0; k < NUM_CH; k++) begin : g_ch
        assign res[k*CHANNEL_BITS +: CHANNEL_BITS] =
            ch_min(ch_min(left[k*CHANNEL_BITS +: CHANNEL_BITS],
                          r_win1[k*CHANNEL_BITS +: CHANNEL_BITS]),
                   right[k*CHANNEL_BITS +: CHANNEL_BITS]);
    end

    assign oq_wdata = {r_d_ctrl.eof, r_d_ctrl.eol, res};

    rgberode_fifo #(
        .WIDTH (OQ_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_d_valid),
        .i_data  (oq_wdata),
        .i_pop   (pop & ~oq_empty),
        .o_data  (oq_rdata),
        .o_empty (oq_empty),
        .o_count (oq_count)
    );

    assign empty          = oq_empty;
    assign o_red_out      = oq_rdata[0 +: CHANNEL_BITS];
    assign o_green_out    = oq_rdata[CHANNEL_BITS +: CHANNEL_BITS];
    assign o_blue_out     = oq_rdata[2*CHANNEL_BITS +: CHANNEL_BITS];
    assign o_end_of_line  = oq_rdata[PIX_W];
    assign o_end_of_frame = oq_rdata[PIX_W+1];

endmodule

### rtl/core/rgb_3x3_erosion_filter.sv
// Top level of the RGB 3x3 erosion filter (per-channel 3x3 minimum).
//
// Input side is a queue write port: a beat moves when push is high and full
// is low. A beat is a pixel (i_kind low) in raster order or a flush beat
// (i_kind high) sent after the frame to drive out the last line of results.
// Result side is a queue read port: the oldest result sits on the o_ ports
// while empty is low and moves when pop is high. Image borders replicate
// the nearest edge pixel; end_of_line and end_of_frame mark the results.
// Results lag the input stream by one line plus one pixel; a result passes the
// front-end registers, the middle queue, the window registers and the result
// queue. Throughput is one beat per cycle while full is low, bound by the
// two-port line store (one read and one write per cycle) and the window shift
// in the back end. The front and back ends are split by a four-entry queue,
// and the result queue holds four beats, so full rises only when results back
// up. Width and height are written through i_cfg_we / i_cfg_idx / i_cfg_data;
// the user must write them only while the block is idle, which the block itself
// does not enforce. A write restarts the frame. Reset restores 640 x 480 and
// clears all queues; line stores need no clearing pass.
module rgb_3x3_erosion_filter #(
    parameter int MAX_LINE_PIXELS = rgberode_pkg::LINE_PIXELS_DEF,
    parameter int CHANNEL_BITS    = rgberode_pkg::CHANNEL_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rgberode_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rgberode_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                                push,
    output logic                                full,
    input  logic                                i_kind,
    input  logic [CHANNEL_BITS-1:0]             i_red_in,
    input  logic [CHANNEL_BITS-1:0]             i_green_in,
    input  logic [CHANNEL_BITS-1:0]             i_blue_in,
    output logic                                empty,
    input  logic                                pop,
    output logic [CHANNEL_BITS-1:0]             o_red_out,
    output logic [CHANNEL_BITS-1:0]             o_green_out,
    output logic [CHANNEL_BITS-1:0]             o_blue_out,
    output logic                                o_end_of_line,
    output logic                                o_end_of_frame
);
    import rgberode_pkg::*;

    localparam int PIX_W  = NUM_CH * CHANNEL_BITS;
    localparam int CTRL_W = $bits(t_win_ctrl);
    localparam int MQ_W   = CTRL_W + PIX_W;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

    logic             mq_push, mq_pop, mq_empty;
    logic [CNT_W-1:0] mq_count;
    t_win_ctrl        f_ctrl, b_ctrl;
    logic [PIX_W-1:0] f_colmin, b_colmin;
    logic [MQ_W-1:0]  mq_wdata, mq_rdata;

    rgberode_front #(
        .MAX_LINE_PIXELS (MAX_LINE_PIXELS),
        .CHANNEL_BITS    (CHANNEL_BITS),
        .QUEUE_DEPTH     (QUEUE_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .push       (push),
        .full       (full),
        .i_kind     (i_kind),
        .i_red_in   (i_red_in),
        .i_green_in (i_green_in),
        .i_blue_in  (i_blue_in),
        .i_mq_count (mq_count),
        .o_mq_push  (mq_push),
        .o_ctrl     (f_ctrl),
        .o_colmin   (f_colmin)
    );

    assign mq_wdata = {f_ctrl, f_colmin};

    rgberode_fifo #(
        .WIDTH (MQ_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mq_push),
        .i_data  (mq_wdata),
        .i_pop   (mq_pop),
        .o_data  (mq_rdata),
        .o_empty (mq_empty),
        .o_count (mq_count)
    );

    assign b_ctrl   = t_win_ctrl'(mq_rdata[MQ_W-1:PIX_W]);
    assign b_colmin = mq_rdata[PIX_W-1:0];

    rgberode_back #(
        .CHANNEL_BITS (CHANNEL_BITS),
        .QUEUE_DEPTH  (QUEUE_DEPTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_mq_empty     (mq_empty),
        .i_ctrl         (b_ctrl),
        .i_colmin       (b_colmin),
        .o_mq_pop       (mq_pop),
        .pop            (pop),
        .empty          (empty),
        .o_red_out      (o_red_out),
        .o_green_out    (o_green_out),
        .o_blue_out     (o_blue_out),
        .o_end_of_line  (o_end_of_line),
        .o_end_of_frame (o_end_of_frame)
    );

endmodule
